[rtl/lcg48_pkg.sv]
// Shared types and constants for the 48-bit linear congruential generator.
// No dependencies; used by lcg48_stepper and lcg48_random_generator_core.
package lcg48_pkg;

   localparam int StateWidth = 48;
   localparam int MulWidth   = 35;

   // Scrambling multiplier and increment of the recurrence.
   localparam logic [MulWidth-1:0]   LcgMul = {15'h5DEE, 20'hCE66D};
   localparam logic [StateWidth-1:0] LcgAdd = 48'hB;

   // Request function codes.
   localparam logic [2:0] FuncBits  = 3'd0;
   localparam logic [2:0] FuncBound = 3'd1;
   localparam logic [2:0] FuncFrac  = 3'd2;
   localparam logic [2:0] FuncBool  = 3'd3;
   localparam logic [2:0] FuncBytes = 3'd4;

   typedef struct packed {
      logic [2:0]         func;
      logic [5:0]         bit_count;
      logic signed [31:0] bound;
      logic [6:0]         byte_count;
   } req_type;

   typedef struct packed {
      logic [52:0] value;
      logic        last;
   } rsp_type;

endpackage

[rtl/lcg48_stepper.sv]
// One advance of the 48-bit recurrence, computed in three 16-bit chunk steps with a
// single 16 x 35 multiply-accumulate unit. Depends on lcg48_pkg.
module lcg48_stepper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lcg48_pkg::StateWidth-1:0]    state,
   output logic                                done,
   output logic [lcg48_pkg::StateWidth-1:0]    next_state
);

   logic [lcg48_pkg::StateWidth-1:0] src_ff, src_in;
   logic [lcg48_pkg::StateWidth-1:0] acc_ff, acc_in;
   logic [1:0]                       idx_ff, idx_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic [15:0]                      chunk;
   logic [50:0]                      prod;
   logic [lcg48_pkg::StateWidth-1:0] term;

   always_comb begin
      unique case (idx_ff)
         2'd0:    chunk = src_ff[15:0];
         2'd1:    chunk = src_ff[31:16];
         default: chunk = src_ff[47:32];
      endcase
      prod = 51'(chunk) * 51'(lcg48_pkg::LcgMul);
      unique case (idx_ff)
         2'd0:    term = prod[47:0];
         2'd1:    term = {prod[31:0], 16'h0};
         default: term = {prod[15:0], 32'h0};
      endcase
   end

   always_comb begin
      src_in  = src_ff;
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         src_in  = state;
         acc_in  = lcg48_pkg::LcgAdd;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + term;
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      src_ff <= src_in;
      acc_ff <= acc_in;
   end

   assign done       = done_ff;
   assign next_state = acc_ff;

endmodule

[rtl/lcg48_random_generator_core.sv]
// Top level of the 48-bit linear congruential random generator; uses lcg48_pkg, lcg48_stepper.
// A state advance runs in lcg48_stepper. Bit, boolean and power-of-two bound beats use it
// directly, a fraction draws again for its low bits, a non-positive bound skips the draw, and
// other bounds run a 31-step serial remainder per draw, redrawing on rejection. Byte runs cost
// one advance per four bytes, then a beat per cycle while unstalled; one request at a time, the
// next accepted after the last beat. Synchronous reset loads the scrambled zero seed.
module lcg48_random_generator_core #(
   parameter int MAX_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lcg48_pkg::req_type   req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcg48_pkg::rsp_type   rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [47:0]          csr_write_data
);

   localparam logic [6:0] MaxBytesW = 7'(MAX_BYTES);

   // The sequencer: one advance at a time, then use of the drawn bits,
   // the serial remainder with its rejection check, and beat delivery.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STEP  = 6'b000010,
      ST_USE   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_EMIT  = 6'b100000
   } fsm_type;

   fsm_type     fsm_ff, fsm_in;

   logic [47:0] state_ff, state_in;
   logic [2:0]  func_ff, func_in;
   logic [5:0]  bits_ff, bits_in;
   logic [31:0] bound_ff, bound_in;
   logic        pow2_ff, pow2_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  idx_ff, idx_in;
   logic        phase_ff, phase_in;
   logic [31:0] word_ff, word_in;
   logic [52:0] pend_ff, pend_in;
   logic [30:0] rem_ff, rem_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic        wait_ff, wait_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lcg48_pkg::rsp_type rsp_ff, rsp_in;

   logic        step_start;
   logic        step_done;
   logic [47:0] step_next;

   lcg48_stepper u_stepper (
      .clock      (clock),
      .reset      (reset),
      .start      (step_start),
      .state      (state_ff),
      .done       (step_done),
      .next_state (step_next)
   );

   // Top k bits of the state; zero width gives zero, widths above 32 act as 32.
   function automatic logic [31:0] top_bits(input logic [47:0] s, input logic [5:0] k);
      logic [5:0] kk;
      logic [47:0] sh;
      kk = (k > 6'd32) ? 6'd32 : k;
      sh = s >> (6'd48 - kk);
      return (k == 6'd0) ? 32'h0 : sh[31:0];
   endfunction

   logic [30:0] draw31;
   logic [62:0] pow2_prod;
   logic [31:0] div_trial;
   logic [31:0] div_diff;
   logic [5:0]  bit_sel;
   logic [31:0] reject_sum;
   logic        slot_free;
   logic        emit_last;
   logic        req_accept;

   assign draw31     = state_ff[47:17];
   assign pow2_prod  = 63'(bound_ff) * 63'(draw31);
   assign bit_sel    = 6'd17 + {1'b0, div_cnt_ff};
   assign div_trial  = {rem_ff, state_ff[bit_sel]};
   assign div_diff   = div_trial - bound_ff;
   // The draw is refused when draw - rem + (bound - 1) wraps negative.
   assign reject_sum = {1'b0, draw31} - {1'b0, rem_ff} + (bound_ff - 32'd1);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last  = (func_ff != lcg48_pkg::FuncBytes) || (idx_ff + 7'd1 == cnt_ff);
   assign req_accept = req_valid && (fsm_ff == ST_IDLE);
   assign step_start = (fsm_ff == ST_STEP) && !wait_ff;

   always_comb begin
      fsm_in       = fsm_ff;
      state_in     = state_ff;
      func_in      = func_ff;
      bits_in      = bits_ff;
      bound_in     = bound_ff;
      pow2_in      = pow2_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      pend_in      = pend_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      wait_in      = wait_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in  = req_payload.func;
               bits_in  = req_payload.bit_count;
               bound_in = req_payload.bound;
               pow2_in  = (req_payload.bound & (req_payload.bound - 32'sd1)) == 32'sd0;
               cnt_in   = (req_payload.byte_count > MaxBytesW) ? MaxBytesW
                                                             : req_payload.byte_count;
               idx_in   = 7'd0;
               phase_in = 1'b0;
               priority if (req_payload.func > lcg48_pkg::FuncBytes) begin
                  fsm_in = ST_IDLE;
               end else if (req_payload.func == lcg48_pkg::FuncBound &&
                            (req_payload.bound[31] || req_payload.bound == 32'sd0)) begin
                  // A non-positive bound answers zero without drawing.
                  pend_in = 53'h0;
                  fsm_in  = ST_EMIT;
               end else if (req_payload.func == lcg48_pkg::FuncBytes &&
                            req_payload.byte_count == 7'd0) begin
                  fsm_in = ST_IDLE;
               end else begin
                  fsm_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            wait_in = 1'b1;
            if (step_done) begin
               state_in = step_next;
               wait_in  = 1'b0;
               fsm_in   = ST_USE;
            end
         end
         ST_USE: begin
            unique case (func_ff)
               lcg48_pkg::FuncBits: begin
                  pend_in = 53'(top_bits(state_ff, bits_ff));
                  fsm_in  = ST_EMIT;
               end
               lcg48_pkg::FuncBound: begin
                  if (pow2_ff) begin
                     pend_in = 53'(pow2_prod[62:31]);
                     fsm_in  = ST_EMIT;
                  end else begin
                     rem_in     = 31'h0;
                     div_cnt_in = 5'd30;
                     fsm_in     = ST_DIV;
                  end
               end
               lcg48_pkg::FuncFrac: begin
                  if (!phase_ff) begin
                     pend_in  = {state_ff[47:22], 27'h0};
                     phase_in = 1'b1;
                     fsm_in   = ST_STEP;
                  end else begin
                     pend_in = {pend_ff[52:27], state_ff[47:21]};
                     fsm_in  = ST_EMIT;
                  end
               end
               lcg48_pkg::FuncBool: begin
                  pend_in = 53'(state_ff[47]);
                  fsm_in  = ST_EMIT;
               end
               default: begin
                  word_in = state_ff[47:16];
                  fsm_in  = ST_EMIT;
               end
            endcase
         end
         ST_DIV: begin
            // One restoring remainder step per cycle, draw bits high first.
            rem_in     = div_diff[31] ? div_trial[30:0] : div_diff[30:0];
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd0) begin
               fsm_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (reject_sum[31]) begin
               fsm_in = ST_STEP;
            end else begin
               pend_in = 53'(rem_ff);
               fsm_in  = ST_EMIT;
            end
         end
         default: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = emit_last;
               rsp_in.value = (func_ff == lcg48_pkg::FuncBytes) ? 53'(word_ff[7:0]) : pend_ff;
               word_in      = word_ff >> 8;
               idx_in       = idx_ff + 7'd1;
               priority if (emit_last) begin
                  fsm_in = ST_IDLE;
               end else if (idx_ff[1:0] == 2'd3) begin
                  fsm_in = ST_STEP;
               end else begin
                  fsm_in = ST_EMIT;
               end
            end
         end
      endcase

      // A seed write reloads the state; the user must send it only while the block idles (not enforced).
      if (csr_write_enable) begin
         state_in = csr_write_data ^ 48'(lcg48_pkg::LcgMul);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         state_ff     <= 48'(lcg48_pkg::LcgMul);
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      bits_ff    <= bits_in;
      bound_ff   <= bound_in;
      pow2_ff    <= pow2_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      phase_ff   <= phase_in;
      word_ff    <= word_in;
      pend_ff    <= pend_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (fsm_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for lcg48_random_generator_core: directed and random requests
// checked beat by beat against an in-bench predictor of the 48-bit LCG.
// Depends on lcg48_pkg and the generator RTL only.
module tb_top;

   localparam int MaxBytes       = 64;
   localparam int ResetCycles    = 10;
   // Longest service time per request is dominated by the serial remainder.
   // Requests that produce no beats may still be in flight, so idle waits use this margin.
   localparam int DrainCycles    = 120;
   localparam int HoldOffCycles  = 600;
   localparam int RandomItems    = 112;
   localparam int CycleLimit     = 2_000_000;
   localparam int ReportLimit    = 10;

   // Function codes that the block decodes as no-ops.
   localparam logic [2:0] FuncUnusedFirst = 3'd5;
   localparam logic [2:0] FuncUnusedLast  = 3'd7;

   localparam logic [47:0] Mul48    = {13'd0, lcg48_pkg::LcgMul};
   localparam logic [47:0] AllOnes48 = 48'hFFFF_FFFF_FFFF;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   lcg48_pkg::req_type  req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   lcg48_pkg::rsp_type  rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [47:0]         csr_write_data = '0;

   // Predictor state: mirrors the generator's 48-bit recurrence.
   logic [47:0]         lcg_state = Mul48;
   lcg48_pkg::rsp_type  expected_beats[$];

   int            cycle_count = 0;
   int            mismatch_count = 0;
   int            beats_checked = 0;
   int            seed_writes = 0;
   int            requests_by_func[8];
   int            unused_requests = 0;
   int            result_requests = 0;
   bit            sender_gaps_on = 1'b1;

   // Hold-off handshake between the test sequence and the stall driver.
   int            hold_off_requests = 0;
   int            hold_off_served = 0;
   int            hold_left = 0;
   int            stall_left = 0;
   int            run_left = 0;

   lcg48_random_generator_core #(
      .MAX_BYTES(MaxBytes)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a correct run finishes far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d beats still expected.",
                  cycle_count, expected_beats.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Gap lengths shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 11) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Predictor of the generator.
   // ---------------------------------------------------------------------------------------

   // One step of the recurrence, then the top k bits of the new state.
   // A zero count still advances the state; counts above 32 are clipped to 32.
   function automatic logic [31:0] lcg_draw(int k);
      lcg_state = lcg_state * Mul48 + lcg48_pkg::LcgAdd;
      if (k == 0) return 32'd0;
      if (k > 32) k = 32;
      return 32'(lcg_state >> (48 - k));
   endfunction

   // Bounded integer below a positive n. Powers of two use multiply-shift; other bounds
   // take a 31-bit draw modulo n and redraw while the top bucket would be partial, which
   // shows up as the 32-bit sum below going negative.
   function automatic logic [63:0] bounded_draw(logic [31:0] n);
      logic [31:0] raw, rem;
      if ((n & (n - 32'd1)) == 32'd0)
         return (64'(n) * 64'(lcg_draw(31))) >> 31;
      do begin
         raw = lcg_draw(31);
         rem = raw % n;
      end while (((raw - rem + (n - 32'd1)) & 32'h8000_0000) != 32'd0);
      return 64'(rem);
   endfunction

   function automatic void push_beat(logic [63:0] value, logic last);
      lcg48_pkg::rsp_type beat;
      beat.value = value[52:0];
      beat.last  = last;
      expected_beats.push_back(beat);
   endfunction

   // Appends the beats that one accepted request produces and returns their number.
   function automatic int predict_request(lcg48_pkg::req_type item);
      logic [31:0] n, word;
      logic [63:0] v;
      int count;
      count = 1;
      n = item.bound;
      word = '0;
      case (item.func)
         lcg48_pkg::FuncBits: push_beat(64'(lcg_draw(int'(item.bit_count))), 1'b1);
         lcg48_pkg::FuncBound: begin
            // Zero or negative bound answers 0 without touching the state.
            if (n == 32'd0 || n[31]) push_beat(64'd0, 1'b1);
            else push_beat(bounded_draw(n), 1'b1);
         end
         lcg48_pkg::FuncFrac: begin
            v = 64'(lcg_draw(26)) << 27;
            v = v + 64'(lcg_draw(27));
            push_beat(v, 1'b1);
         end
         lcg48_pkg::FuncBool: push_beat(64'(lcg_draw(1)), 1'b1);
         lcg48_pkg::FuncBytes: begin
            count = (item.byte_count > MaxBytes) ? MaxBytes : int'(item.byte_count);
            for (int i = 0; i < count; i++) begin
               // One 32-bit draw feeds four byte beats, low byte first.
               if (i % 4 == 0) word = lcg_draw(32);
               else word = word >> 8;
               push_beat(64'(word[7:0]), i == count - 1);
            end
         end
         default: count = 0;
      endcase
      return count;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------------------

   function automatic lcg48_pkg::req_type make_request(logic [2:0] func, logic [5:0] bits,
                                                       logic [31:0] bound, logic [6:0] bytes);
      lcg48_pkg::req_type item;
      item.func       = func;
      item.bit_count  = bits;
      item.bound      = bound;
      item.byte_count = bytes;
      return item;
   endfunction

   // Offers one request and returns once it is accepted. Valid is left high so that a
   // following call in the same step can present the next request without a bubble; any
   // caller that stops sending lowers it through wait_idle.
   task automatic send_request(input lcg48_pkg::req_type item);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      requests_by_func[item.func]++;
      if (item.func > lcg48_pkg::FuncBytes) unused_requests++;
      if (predict_request(item) > 0) result_requests++;
   endtask

   // Returns with the generator idle: nothing offered, nothing owed, and enough extra
   // cycles for a request that yields no beat to have finished.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_seed(input logic [47:0] seed);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= seed;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lcg_state = seed ^ Mul48;
      seed_writes++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: stall driver and checker.
   // ---------------------------------------------------------------------------------------

   // Stall pattern alternates a stalled stretch with a free-running stretch; some free
   // stretches are long so that back-to-back beats also get exercised. A hold-off request
   // from the test sequence overrides the pattern with an unbroken stall stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_left = HoldOffCycles - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic flag_mismatch(input string what, input logic [52:0] want,
                                input logic [52:0] got);
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
         $display("Mismatch at cycle %0d on %s: expected 0x%0h, got 0x%0h",
                  cycle_count, what, want, got);
   endtask

   // Every accepted beat is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      lcg48_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            flag_mismatch("unexpected beat value", 53'd0, rsp_payload.value);
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_payload.value !== want.value)
               flag_mismatch("value", want.value, rsp_payload.value);
            if (rsp_payload.last !== want.last)
               flag_mismatch("last flag", 53'(want.last), 53'(rsp_payload.last));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Raw top bits: zero count, the edges of the legal range and counts past 32.
   task automatic test_top_bits();
      send_request(make_request(lcg48_pkg::FuncBits, 6'd0,  '0, '0));
      send_request(make_request(lcg48_pkg::FuncBits, 6'd1,  '0, '0));
      send_request(make_request(lcg48_pkg::FuncBits, 6'd32, '0, '0));
      send_request(make_request(lcg48_pkg::FuncBits, 6'd33, '0, '0));
      send_request(make_request(lcg48_pkg::FuncBits, 6'd63, '0, '0));
   endtask

   // Bounded integers: non-positive bounds, a bound of one, powers of two, the largest
   // bound, and a bound just above 2^30 where about half the draws get rejected.
   task automatic test_bounded();
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'd0, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'hFFFF_FFFF, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'h8000_0000, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'd1, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'h4000_0000, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'h7FFF_FFFF, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'h4000_0001, '0));
      send_request(make_request(lcg48_pkg::FuncBound, '0, 32'd7, '0));
   endtask

   task automatic test_fraction_and_boolean();
      send_request(make_request(lcg48_pkg::FuncFrac, '0, '0, '0));
      send_request(make_request(lcg48_pkg::FuncBool, '0, '0, '0));
      send_request(make_request(lcg48_pkg::FuncBool, '0, '0, '0));
   endtask

   // Byte runs: empty, single, one draw plus a byte, the maximum and a saturating count.
   task automatic test_byte_runs();
      send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd0));
      send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd1));
      send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd5));
      send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd64));
      send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd127));
   endtask

   // Undefined function codes must be swallowed without a beat or a state change.
   task automatic test_unused_funcs();
      for (int f = FuncUnusedFirst; f <= FuncUnusedLast; f++)
         send_request(make_request(3'(f), 6'(f * 9), $urandom, 7'(f * 20)));
      send_request(make_request(lcg48_pkg::FuncBits, 6'd32, '0, '0));
   endtask

   // Seed extremes; seeding with the multiplier itself zeroes the state.
   task automatic test_seed_extremes();
      logic [47:0] seeds[3];
      seeds[0] = '0;
      seeds[1] = AllOnes48;
      seeds[2] = Mul48;
      foreach (seeds[s]) begin
         write_seed(seeds[s]);
         send_request(make_request(lcg48_pkg::FuncBits, 6'd32, '0, '0));
         send_request(make_request(lcg48_pkg::FuncFrac, '0, '0, '0));
         send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd6));
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering long byte runs,
   // with a bit request every third, back to back, so the block's output backs up into its request port.
   task automatic test_back_pressure();
      write_seed({$urandom, 16'($urandom)});
      sender_gaps_on = 1'b0;
      hold_off_requests <= hold_off_requests + 1;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2)
            send_request(make_request(lcg48_pkg::FuncBits, 6'($urandom_range(1, 32)), '0, '0));
         else
            send_request(make_request(lcg48_pkg::FuncBytes, '0, '0, 7'd64));
      end
      sender_gaps_on = 1'b1;
   endtask

   function automatic lcg48_pkg::req_type random_request();
      lcg48_pkg::req_type item;
      int roll;
      item = make_request(3'($urandom_range(0, 4)), 6'($urandom_range(0, 63)), $urandom,
                          7'($urandom_range(1, 16)));
      if ($urandom_range(0, 99) < 5)
         item.func = 3'($urandom_range(FuncUnusedFirst, FuncUnusedLast));
      roll = $urandom_range(0, 9);
      case (roll)
         1, 2: item.bound = 32'd1 << $urandom_range(0, 30);
         3: item.bound = 32'h4000_0000 + $urandom_range(1, 32'h000F_FFFF);
         4, 5, 6: item.bound = $urandom_range(2, 1000);
         7, 8: item.bound = $urandom_range(1, 32'h7FFF_FFFF);
         default: ;
      endcase
      roll = $urandom_range(0, 9);
      if (roll == 8) item.byte_count = 7'($urandom_range(17, 64));
      else if (roll == 9) item.byte_count = 7'($urandom_range(0, 127));
      return item;
   endfunction

   // Random mix in four phases, each under its own seed; the second phase runs with no
   // request gaps. Only requests that produce beats count toward the total.
   task automatic test_random_mix();
      int goal;
      goal = result_requests + RandomItems;
      for (int phase = 0; phase < 4; phase++) begin
         write_seed({$urandom, 16'($urandom)});
         sender_gaps_on = (phase != 1);
         while (result_requests < goal - (3 - phase) * RandomItems / 4)
            send_request(random_request());
      end
      sender_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_top_bits();
      test_bounded();
      test_fraction_and_boolean();
      test_byte_runs();
      test_unused_funcs();
      test_seed_extremes();
      test_back_pressure();
      test_random_mix();
      wait_idle();

      $display("Checked %0d beats from %0d requests: bits %0d, bounded %0d, fraction %0d,",
               beats_checked, requests_by_func.sum(), requests_by_func[lcg48_pkg::FuncBits],
               requests_by_func[lcg48_pkg::FuncBound], requests_by_func[lcg48_pkg::FuncFrac]);
      $display("boolean %0d, byte runs %0d, unused codes %0d; %0d seed writes, %0d mismatches.",
               requests_by_func[lcg48_pkg::FuncBool], requests_by_func[lcg48_pkg::FuncBytes],
               unused_requests, seed_writes, mismatch_count);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
